// ===== hdl/sktab_pkg.sv =====
// sktab_pkg: shared types and constants for the sorted key table.
// Holds field widths, operation and status codes, controller commands
// and the status group that the datapath reports back.
package sktab_pkg;

  localparam int CAPACITY_DEFAULT = 64;

  localparam int OP_W     = 2;
  localparam int YEAR_W   = 16;
  localparam int FLOW_W   = 32;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 3;
  localparam int TOTAL_W  = 7;

  // Request operation codes; code 3 has no meaning and reads as out of range
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED     = 3'd0,
    ST_REMOVED      = 3'd1,
    ST_NOT_FOUND    = 3'd2,
    ST_FULL         = 3'd3,
    ST_READ_OK      = 3'd4,
    ST_OUT_OF_RANGE = 3'd5
  } status_t;

  // Commands from the controller to the datapath, one per cycle
  typedef enum logic [2:0] {
    CMD_NONE       = 3'd0,
    CMD_LOAD       = 3'd1,
    CMD_DECIDE     = 3'd2,
    CMD_INS_STEP   = 3'd3,
    CMD_SCAN_STEP  = 3'd4,
    CMD_SHIFT_STEP = 3'd5,
    CMD_PUSH       = 3'd6
  } cmd_t;

  // Datapath flags seen by the controller
  typedef struct packed {
    logic is_insert;
    logic is_remove;
    logic full;
    logic ins_move;
    logic scan_end;
    logic match;
    logic shift_more;
    logic out_free;
  } dp_status_t;

  // One table entry as stored in memory
  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [FLOW_W-1:0] flow;
  } entry_t;

endpackage

// ===== hdl/sorted_key_table_top.sv =====
// sorted_key_table_top: bounded table of (year, flow) records kept sorted
// by ascending year, with insert, remove by year and read by position.
// Usage:
//   Request channel (req_valid/req_stall): operation, key_year, flow_word,
//   position. A request is taken when req_valid is high and req_stall low.
//   Result channel (rsp_valid/rsp_stall): status, out_year, out_flow and
//   entry_total, one result per request, held in an output register.
// Steps from the accepting edge to rsp_valid, after load and decide:
//   read, full insert or unused code: straight to the output register.
//   insert: move each entry with year >= key up by one, then write the
//   new record. remove: scan to the match, then shift the entries after
//   it down by one; with no match the scan runs to the end.
// Throughput: one request at a time; the next one is taken once the
//   controller is back in idle after loading the result. Inserts and
//   removes walk the entry memory one entry a cycle over its single
//   write port and single registered read port.
// Reset clears the entry count and the output valid; memory contents are
// not cleared, since entries at or above the count are never used.
// While the receiver stalls, the result holds; the table still takes the
// next request and finishes it, then waits until the output register frees.
module sorted_key_table_top #(
  parameter int CAPACITY = sktab_pkg::CAPACITY_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [sktab_pkg::OP_W-1:0]          operation,
  input  logic [sktab_pkg::YEAR_W-1:0]        key_year,
  input  logic [sktab_pkg::FLOW_W-1:0]        flow_word,
  input  logic [sktab_pkg::POS_W-1:0]         position,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic [sktab_pkg::STATUS_W-1:0]      status,
  output logic [sktab_pkg::YEAR_W-1:0]        out_year,
  output logic [sktab_pkg::FLOW_W-1:0]        out_flow,
  output logic [sktab_pkg::TOTAL_W-1:0]       entry_total
);

  sktab_pkg::cmd_t       cmd;
  sktab_pkg::dp_status_t st;

  // Sequence each request
  sktab_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // Store entries and build results
  sktab_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .operation   (operation),
    .key_year    (key_year),
    .flow_word   (flow_word),
    .position    (position),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .out_year    (out_year),
    .out_flow    (out_flow),
    .entry_total (entry_total)
  );

endmodule

// ===== hdl/sktab_ctrl.sv =====
// sktab_ctrl: sequencing state machine of the sorted key table.
// Depends on sktab_pkg for commands and the datapath status group.
module sktab_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  sktab_pkg::dp_status_t  st,
  output sktab_pkg::cmd_t        cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_INS    = 6'b000100,
    S_SCAN   = 6'b001000,
    S_SHIFT  = 6'b010000,
    S_FIN    = 6'b100000
  } ctrl_state_t;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // Take a request only while idle
  assign req_stall = (state != S_IDLE);

  // Pick the command and the next state
  always_comb begin
    state_next = state;
    cmd        = sktab_pkg::CMD_NONE;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd        = sktab_pkg::CMD_LOAD;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd = sktab_pkg::CMD_DECIDE;
        if (st.is_insert && !st.full) begin
          state_next = S_INS;
        end else if (st.is_remove) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_FIN;
        end
      end
      S_INS: begin
        cmd = sktab_pkg::CMD_INS_STEP;
        if (!st.ins_move) begin
          state_next = S_FIN;
        end
      end
      S_SCAN: begin
        cmd = sktab_pkg::CMD_SCAN_STEP;
        if (st.scan_end) begin
          state_next = S_FIN;
        end else if (st.match) begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd = sktab_pkg::CMD_SHIFT_STEP;
        if (!st.shift_more) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd        = sktab_pkg::CMD_PUSH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/sktab_dp.sv =====
// sktab_dp: datapath of the sorted key table: entry memory, walk index,
// entry count, result registers and the output register.
// Depends on sktab_pkg; driven by commands from sktab_ctrl.
module sktab_dp #(
  parameter int CAPACITY = sktab_pkg::CAPACITY_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sktab_pkg::cmd_t                     cmd,
  output sktab_pkg::dp_status_t               st,
  input  logic [sktab_pkg::OP_W-1:0]          operation,
  input  logic [sktab_pkg::YEAR_W-1:0]        key_year,
  input  logic [sktab_pkg::FLOW_W-1:0]        flow_word,
  input  logic [sktab_pkg::POS_W-1:0]         position,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic [sktab_pkg::STATUS_W-1:0]      status,
  output logic [sktab_pkg::YEAR_W-1:0]        out_year,
  output logic [sktab_pkg::FLOW_W-1:0]        out_flow,
  output logic [sktab_pkg::TOTAL_W-1:0]       entry_total
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > sktab_pkg::POS_W) ? CW : sktab_pkg::POS_W;

  // Entry memory, one write and one registered read per cycle
  sktab_pkg::entry_t mem [CAPACITY];
  sktab_pkg::entry_t rd_q;
  sktab_pkg::entry_t wr_data;
  logic              rd_en;
  logic              wr_en;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;

  // Request and walk registers
  logic [sktab_pkg::OP_W-1:0]   op_r;
  logic [sktab_pkg::YEAR_W-1:0] key_r;
  logic [sktab_pkg::FLOW_W-1:0] flow_r;
  logic [sktab_pkg::POS_W-1:0]  pos_r;
  logic [CW-1:0]                idx;
  logic [CW-1:0]                count;

  // Pending result
  sktab_pkg::status_t           res_status;
  logic [sktab_pkg::YEAR_W-1:0] res_year;
  logic [sktab_pkg::FLOW_W-1:0] res_flow;

  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_ext;
  logic            pos_ok;

  // Compare flags
  assign pos_ext = CMPW'(pos_r);
  assign cnt_ext = CMPW'(count);
  assign pos_ok  = (pos_ext < cnt_ext);

  assign st.is_insert  = (op_r == sktab_pkg::OP_INSERT);
  assign st.is_remove  = (op_r == sktab_pkg::OP_REMOVE);
  assign st.full       = (count >= CW'(CAPACITY));
  assign st.ins_move   = (idx != '0) && (rd_q.year >= key_r);
  assign st.scan_end   = (idx >= count);
  assign st.match      = (rd_q.year == key_r);
  assign st.shift_more = (({1'b0, idx} + (CW+1)'(1)) < {1'b0, count});
  assign st.out_free   = !rsp_valid || !rsp_stall;

  // Drive the memory ports from the command
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = AW'(idx);
    wr_data = rd_q;
    case (cmd)
      sktab_pkg::CMD_LOAD: begin
        rd_en = 1'b1;
        case (operation)
          sktab_pkg::OP_INSERT: rd_addr = AW'(count - CW'(1));
          sktab_pkg::OP_REMOVE: rd_addr = '0;
          default:              rd_addr = AW'(position);
        endcase
      end
      sktab_pkg::CMD_INS_STEP: begin
        wr_en = 1'b1;
        if (st.ins_move) begin
          rd_en   = 1'b1;
          rd_addr = AW'(idx - CW'(2));
        end else begin
          wr_data = '{year: key_r, flow: flow_r};
        end
      end
      sktab_pkg::CMD_SCAN_STEP: begin
        rd_en   = !st.scan_end;
        rd_addr = AW'(idx + CW'(1));
      end
      sktab_pkg::CMD_SHIFT_STEP: begin
        if (st.shift_more) begin
          wr_en   = 1'b1;
          rd_en   = 1'b1;
          rd_addr = AW'(idx + CW'(2));
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Latch the request, walk the index and build the result
  always_ff @(posedge clk) begin
    case (cmd)
      sktab_pkg::CMD_LOAD: begin
        op_r   <= operation;
        key_r  <= key_year;
        flow_r <= flow_word;
        pos_r  <= position;
        idx    <= (operation == sktab_pkg::OP_REMOVE) ? '0 : count;
      end
      sktab_pkg::CMD_DECIDE: begin
        res_year <= '0;
        res_flow <= '0;
        if (st.is_insert) begin
          res_status <= st.full ? sktab_pkg::ST_FULL : sktab_pkg::ST_INSERTED;
        end else if (st.is_remove) begin
          res_status <= sktab_pkg::ST_NOT_FOUND;
        end else if ((op_r == sktab_pkg::OP_READ) && pos_ok) begin
          res_status <= sktab_pkg::ST_READ_OK;
          res_year   <= rd_q.year;
          res_flow   <= rd_q.flow;
        end else begin
          res_status <= sktab_pkg::ST_OUT_OF_RANGE;
        end
      end
      sktab_pkg::CMD_INS_STEP: begin
        if (st.ins_move) begin
          idx <= idx - CW'(1);
        end
      end
      sktab_pkg::CMD_SCAN_STEP: begin
        if (!st.scan_end) begin
          if (st.match) begin
            res_status <= sktab_pkg::ST_REMOVED;
            res_year   <= rd_q.year;
            res_flow   <= rd_q.flow;
          end else begin
            idx <= idx + CW'(1);
          end
        end
      end
      sktab_pkg::CMD_SHIFT_STEP: begin
        if (st.shift_more) begin
          idx <= idx + CW'(1);
        end
      end
      sktab_pkg::CMD_PUSH: begin
        status      <= res_status;
        out_year    <= res_year;
        out_flow    <= res_flow;
        entry_total <= sktab_pkg::TOTAL_W'(count);
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

  // Count entries: grow at the end of an insert, shrink at the end of a remove
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if ((cmd == sktab_pkg::CMD_INS_STEP) && !st.ins_move) begin
      count <= count + CW'(1);
    end else if ((cmd == sktab_pkg::CMD_SHIFT_STEP) && !st.shift_more) begin
      count <= count - CW'(1);
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd == sktab_pkg::CMD_PUSH) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

// ===== test/tb_sorted_key_table_top.sv =====
// Testbench for sorted_key_table_top: inserts, removes and reads are driven
// over the request channel and checked against a table model in the scoreboard.
// Depends on sktab_pkg and the sorted_key_table_top RTL only.

typedef struct {
  sktab_pkg::status_t               status;
  logic [sktab_pkg::YEAR_W-1:0]     year;
  logic [sktab_pkg::FLOW_W-1:0]     flow;
  logic [sktab_pkg::TOTAL_W-1:0]    total;
} table_result_t;

typedef struct {
  logic [sktab_pkg::OP_W-1:0]       op;
  logic [sktab_pkg::YEAR_W-1:0]     year;
  logic [sktab_pkg::FLOW_W-1:0]     flow;
  logic [sktab_pkg::POS_W-1:0]      pos;
} table_request_t;

class table_scoreboard;
  localparam int DEPTH = sktab_pkg::CAPACITY_DEFAULT;

  logic [sktab_pkg::YEAR_W-1:0] years [DEPTH];
  logic [sktab_pkg::FLOW_W-1:0] flows [DEPTH];
  int                           count;
  table_result_t                results_due [$];
  int                           mismatches;

  function new();
    count      = 0;
    mismatches = 0;
  endfunction

  // Apply one request to the table model and return the result it yields
  function table_result_t apply_table_op(table_request_t rq);
    table_result_t r;
    int            slot;
    r.status = sktab_pkg::ST_OUT_OF_RANGE;
    r.year   = '0;
    r.flow   = '0;
    slot     = -1;
    case (rq.op)
      sktab_pkg::OP_INSERT: begin
        if (count >= DEPTH) begin
          r.status = sktab_pkg::ST_FULL;
        end else begin
          // new record goes ahead of any entry with an equal year
          slot = 0;
          while (slot < count && years[slot] < rq.year) slot++;
          for (int i = count; i > slot; i--) begin
            years[i] = years[i-1];
            flows[i] = flows[i-1];
          end
          years[slot] = rq.year;
          flows[slot] = rq.flow;
          count++;
          r.status = sktab_pkg::ST_INSERTED;
        end
      end
      sktab_pkg::OP_REMOVE: begin
        for (int i = 0; i < count; i++) begin
          if (slot < 0 && years[i] == rq.year) slot = i;
        end
        if (slot < 0) begin
          r.status = sktab_pkg::ST_NOT_FOUND;
        end else begin
          r.status = sktab_pkg::ST_REMOVED;
          r.year   = years[slot];
          r.flow   = flows[slot];
          for (int i = slot; i + 1 < count; i++) begin
            years[i] = years[i+1];
            flows[i] = flows[i+1];
          end
          count--;
        end
      end
      sktab_pkg::OP_READ: begin
        if (rq.pos < count) begin
          r.status = sktab_pkg::ST_READ_OK;
          r.year   = years[rq.pos];
          r.flow   = flows[rq.pos];
        end
      end
      default: ;
    endcase
    r.total = count[sktab_pkg::TOTAL_W-1:0];
    return r;
  endfunction

  // Note an accepted request and queue its expected result
  function void note_request(table_request_t rq);
    results_due.push_back(apply_table_op(rq));
  endfunction

  // Compare one result with the oldest expectation
  function void check_result(logic [sktab_pkg::STATUS_W-1:0] status,
                             logic [sktab_pkg::YEAR_W-1:0] year,
                             logic [sktab_pkg::FLOW_W-1:0] flow,
                             logic [sktab_pkg::TOTAL_W-1:0] total);
    table_result_t exp_r;
    if (results_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result status=%0d year=%0d flow=%h total=%0d",
                 $realtime, status, year, flow, total);
      return;
    end
    exp_r = results_due.pop_front();
    if (status !== exp_r.status || year !== exp_r.year ||
        flow !== exp_r.flow || total !== exp_r.total) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: mismatch exp status=%0d year=%0d flow=%h total=%0d, ",
                 $realtime, exp_r.status, exp_r.year, exp_r.flow, exp_r.total,
                 "got status=%0d year=%0d flow=%h total=%0d",
                 status, year, flow, total);
    end
  endfunction

  function int pending();
    return results_due.size();
  endfunction
endclass

module tb_sorted_key_table_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_ITEMS = 275;

  // Operation code with no meaning; the table answers it as out of range
  localparam logic [sktab_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  logic                                clk       = 1'b0;
  logic                                rst       = 1'b1;
  logic                                req_valid = 1'b0;
  logic                                req_stall;
  logic [sktab_pkg::OP_W-1:0]          operation = '0;
  logic [sktab_pkg::YEAR_W-1:0]        key_year  = '0;
  logic [sktab_pkg::FLOW_W-1:0]        flow_word = '0;
  logic [sktab_pkg::POS_W-1:0]         position  = '0;
  logic                                rsp_valid;
  logic                                rsp_stall = 1'b0;
  logic [sktab_pkg::STATUS_W-1:0]      status;
  logic [sktab_pkg::YEAR_W-1:0]        out_year;
  logic [sktab_pkg::FLOW_W-1:0]        out_flow;
  logic [sktab_pkg::TOTAL_W-1:0]       entry_total;

  table_scoreboard sb;
  int  idle_pct  = 0;
  int  stall_pct = 0;
  bit  draining  = 1'b0;

  sorted_key_table_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .operation   (operation),
    .key_year    (key_year),
    .flow_word   (flow_word),
    .position    (position),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .out_year    (out_year),
    .out_flow    (out_flow),
    .entry_total (entry_total)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up after a generous fixed time
  initial begin
    #10ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Check each accepted result, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall)
      sb.check_result(status, out_year, out_flow, entry_total);
    rsp_stall <= !rst && ($urandom_range(0, 99) < stall_pct);
  end

  // Drive one request, optionally after an idle gap, and hold it until taken
  task automatic send_request(table_request_t rq);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < idle_pct)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 80) : $urandom_range(1, 8);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    operation <= rq.op;
    key_year  <= rq.year;
    flow_word <= rq.flow;
    position  <= rq.pos;
    do @(posedge clk); while (req_stall);
    sb.note_request(rq);
  endtask

  function automatic table_request_t make_request(
      logic [sktab_pkg::OP_W-1:0]   op,
      logic [sktab_pkg::YEAR_W-1:0] year,
      logic [sktab_pkg::FLOW_W-1:0] flow,
      logic [sktab_pkg::POS_W-1:0]  pos);
    table_request_t rq;
    rq.op   = op;
    rq.year = year;
    rq.flow = flow;
    rq.pos  = pos;
    return rq;
  endfunction

  // Year keys: mostly a narrow band so that duplicates and matches are common
  function automatic logic [sktab_pkg::YEAR_W-1:0] pick_year();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return sktab_pkg::YEAR_W'($urandom_range(1990, 2010));
    if (sel < 64) return '0;
    if (sel < 68) return '1;
    return sktab_pkg::YEAR_W'($urandom);
  endfunction

  // Build a random request; fill the table toward capacity, then drain it
  function automatic table_request_t random_request();
    table_request_t rq;
    int             sel;
    rq = make_request(sktab_pkg::OP_READ, pick_year(), $urandom,
                      sktab_pkg::POS_W'($urandom));
    if (!draining && sb.count == sktab_pkg::CAPACITY_DEFAULT &&
        $urandom_range(0, 3) == 0)
      draining = 1'b1;
    else if (draining && sb.count == 0 && $urandom_range(0, 3) == 0)
      draining = 1'b0;
    sel = $urandom_range(0, 99);
    if (sel < 2) begin
      rq.op = OP_UNUSED;
    end else if (sel < (draining ? 12 : 77)) begin
      rq.op = sktab_pkg::OP_INSERT;
    end else if (sel < (draining ? 82 : 87)) begin
      rq.op = sktab_pkg::OP_REMOVE;
      if (sb.count > 0 && $urandom_range(0, 9) < 7)
        rq.year = sb.years[$urandom_range(0, sb.count - 1)];
    end else begin
      rq.op = sktab_pkg::OP_READ;
      if (sb.count > 0 && $urandom_range(0, 9) < 8)
        rq.pos = sktab_pkg::POS_W'($urandom_range(0, sb.count - 1));
    end
    return rq;
  endfunction

  initial begin
    int phase_idle  [4] = '{0, 65, 0, 7};
    int phase_stall [4] = '{0, 0, 65, 7};
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, edge keys and flows, duplicates, range limits
    send_request(make_request(sktab_pkg::OP_READ,   16'd0,    32'h0000_0000, 6'd0));
    send_request(make_request(sktab_pkg::OP_REMOVE, 16'd2024, 32'h0000_0000, 6'd0));
    send_request(make_request(OP_UNUSED,            16'd0,    32'h0000_0000, 6'd0));
    send_request(make_request(sktab_pkg::OP_INSERT, 16'd0,    32'h0000_0000, 6'd0));
    send_request(make_request(sktab_pkg::OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 6'd63));
    send_request(make_request(sktab_pkg::OP_INSERT, 16'd1990, 32'hA5A5_A5A5, 6'd0));
    send_request(make_request(sktab_pkg::OP_INSERT, 16'd1990, 32'h5A5A_5A5A, 6'd0));
    for (int p = 0; p < 5; p++)
      send_request(make_request(sktab_pkg::OP_READ, 16'd0, 32'h0,
                                sktab_pkg::POS_W'(p)));
    send_request(make_request(sktab_pkg::OP_READ,   16'hFFFF, 32'hFFFF_FFFF, 6'd63));
    send_request(make_request(sktab_pkg::OP_REMOVE, 16'd1990, 32'h0000_0000, 6'd0));
    send_request(make_request(sktab_pkg::OP_REMOVE, 16'd1777, 32'h0000_0000, 6'd0));
    send_request(make_request(sktab_pkg::OP_REMOVE, 16'hFFFF, 32'h0000_0000, 6'd0));
    send_request(make_request(sktab_pkg::OP_REMOVE, 16'd0,    32'h0000_0000, 6'd0));
    send_request(make_request(OP_UNUSED,            16'hFFFF, 32'hFFFF_FFFF, 6'd63));
    send_request(make_request(sktab_pkg::OP_READ,   16'd0,    32'h0000_0000, 6'd0));
    send_request(make_request(sktab_pkg::OP_REMOVE, 16'd1990, 32'h0000_0000, 6'd0));
    send_request(make_request(sktab_pkg::OP_READ,   16'd0,    32'h0000_0000, 6'd0));

    // Random: one pass per idle and stall mix
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_request(random_request());
    end
    req_valid <= 1'b0;

    // Drain outstanding results, then allow for a late extra one
    while (sb.pending() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
